// ----- sv/sorted_key_table_engine_assert.svh -----
// ----------------------------------------------------------------------------
// sorted key table engine assertion macros
// concurrent checks clocked on clk_i; SKTE_ASSERT is quiet while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_ENGINE_ASSERT_SVH
`define SORTED_KEY_TABLE_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// check held at every edge outside reset
`define SKTE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("skte check failed");

// check that also holds during reset
`define SKTE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("skte check failed in or out of reset");

`else

`define SKTE_ASSERT(lbl, prop)
`define SKTE_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ----- sv/skte_pkg.sv -----
// ----------------------------------------------------------------------------
// skte_pkg
// shared types and constants of the sorted key table engine
// ----------------------------------------------------------------------------
`default_nettype none

package skte_pkg;

  // table geometry
  localparam int CAPACITY = 1024;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // item field widths
  localparam int KEY_W   = 32;
  localparam int POS_W   = 10;
  localparam int WHERE_W = 10;
  localparam int COUNT_W = 11;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_SEARCH = 3'd2,
    CMD_PRED   = 3'd3,
    CMD_SUCC   = 3'd4,
    CMD_MIN    = 3'd5,
    CMD_MAX    = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_BAD  = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [KEY_W-1:0]  key;
    logic [POS_W-1:0]         position;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic signed [KEY_W-1:0]  value;
    logic [WHERE_W-1:0]       where;
    logic [COUNT_W-1:0]       count;
  } out_item_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic signed [KEY_W-1:0]  key;
    logic [IDX_W-1:0]         pos;
    logic [CNT_W-1:0]         count;
  } bcast_t;

endpackage

`default_nettype wire

// ----- sv/sorted_key_table_engine.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table_engine
// A table of signed keys kept in ascending order in a row of cells, one key
// per cell, with an entry count. Each command item gives one result item.
// The accepting edge registers the command, the next edge lets every cell
// compare its key against the broadcast key in parallel and shifts the row by
// one slot on insert or delete, and the read step then reads the selected
// cell and registers the result. The input stalls from acceptance until the
// result is registered, so the block takes no new item before it is through
// with the last one. A waiting result does not block the next item from being
// accepted, only from finishing: that item waits in its read step, with the
// input stalled, until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  skte_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output skte_pkg::out_item_t  out_item_o
);
  import skte_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_READ
  } state_e;

  state_e             state_q, state_d;
  in_item_t           item_q, item_d;
  logic [CNT_W-1:0]   count_q, count_d;
  status_e            status_q, status_d;
  logic [WHERE_W-1:0] where_q, where_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic               need_rd_q, need_rd_d;
  logic               search_q, search_d;
  logic               hit_q, hit_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  bcast_t             bc;
  logic signed [KEY_W-1:0] rd_key;
  logic [CNT_W-1:0]   lb_pos;
  logic [CNT_W-1:0]   pos_c;
  logic               in_acc;
  logic               out_free;

  assign pos_c    = CNT_W'(item_q.position);
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // command broadcast to the cell row
  always_comb begin
    bc       = '0;
    bc.key   = item_q.key;
    bc.pos   = IDX_W'(item_q.position);
    bc.count = count_q;
    bc.ins   = (state_q == S_EVAL) && (item_q.cmd == CMD_INSERT) &&
               (count_q < CNT_W'(CAPACITY));
    bc.del   = (state_q == S_EVAL) && (item_q.cmd == CMD_DELETE) &&
               (pos_c < count_q);
  end

  skte_row u_row (
    .clk_i    (clk_i),
    .bc_i     (bc),
    .rd_idx_i (rd_idx_q),
    .rd_key_o (rd_key),
    .lb_pos_o (lb_pos)
  );

  // sequencer and result formation
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    count_d     = count_q;
    status_d    = status_q;
    where_d     = where_q;
    rd_idx_d    = rd_idx_q;
    need_rd_d   = need_rd_q;
    search_d    = search_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          item_d  = in_item_i;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        status_d  = ST_OK;
        where_d   = '0;
        rd_idx_d  = '0;
        need_rd_d = 1'b0;
        search_d  = 1'b0;
        hit_d     = 1'b0;
        case (item_q.cmd)
          CMD_INSERT: begin
            if (count_q >= CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
            end else begin
              where_d = WHERE_W'(lb_pos);
              count_d = count_q + 1'b1;
            end
          end
          CMD_DELETE: begin
            if (pos_c >= count_q) begin
              status_d = ST_BAD;
            end else begin
              count_d = count_q - 1'b1;
            end
          end
          CMD_SEARCH: begin
            search_d = 1'b1;
            hit_d    = (lb_pos < count_q);
            rd_idx_d = IDX_W'(lb_pos);
            where_d  = WHERE_W'(lb_pos);
          end
          CMD_PRED: begin
            if (pos_c >= count_q) begin
              status_d = ST_BAD;
            end else if (item_q.position == '0) begin
              status_d = ST_MISS;
            end else begin
              rd_idx_d  = IDX_W'(pos_c - 1'b1);
              where_d   = WHERE_W'(pos_c - 1'b1);
              need_rd_d = 1'b1;
            end
          end
          CMD_SUCC: begin
            if (pos_c >= count_q) begin
              status_d = ST_BAD;
            end else if ((pos_c + 1'b1) >= count_q) begin
              status_d = ST_MISS;
            end else begin
              rd_idx_d  = IDX_W'(pos_c + 1'b1);
              where_d   = WHERE_W'(pos_c + 1'b1);
              need_rd_d = 1'b1;
            end
          end
          CMD_MIN: begin
            if (count_q == '0) begin
              status_d = ST_BAD;
            end else begin
              need_rd_d = 1'b1;
            end
          end
          CMD_MAX: begin
            if (count_q == '0) begin
              status_d = ST_BAD;
            end else begin
              rd_idx_d  = IDX_W'(count_q - 1'b1);
              where_d   = WHERE_W'(count_q - 1'b1);
              need_rd_d = 1'b1;
            end
          end
          default: begin
            status_d = ST_BAD;
          end
        endcase
        state_d = S_READ;
      end
      S_READ: begin
        if (out_free) begin
          out_d.status = status_q;
          out_d.value  = need_rd_q ? rd_key : '0;
          out_d.where  = where_q;
          out_d.count  = COUNT_W'(count_q);
          if (search_q) begin
            if (hit_q && (rd_key == item_q.key)) begin
              out_d.status = ST_OK;
              out_d.value  = item_q.key;
            end else begin
              out_d.status = ST_MISS;
              out_d.value  = '0;
              out_d.where  = '0;
            end
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    status_q  <= status_d;
    where_q   <= where_d;
    rd_idx_q  <= rd_idx_d;
    need_rd_q <= need_rd_d;
    search_q  <= search_d;
    hit_q     <= hit_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks
  `include "sorted_key_table_engine_assert.svh"

  `SKTE_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY))
  `SKTE_ASSERT(a_insert_grows, bc.ins |=> (count_q == $past(count_q) + 1'b1))
  `SKTE_ASSERT(a_full_count, (out_valid_q && out_q.status == ST_FULL) |-> (out_q.count == COUNT_W'(CAPACITY)))
  `SKTE_ASSERT(a_fail_zero, (out_valid_q && out_q.status != ST_OK) |-> (out_q.value == '0 && out_q.where == '0))

endmodule

`default_nettype wire

// ----- sv/skte_cell.sv -----
// ----------------------------------------------------------------------------
// skte_cell
// one table slot: holds a key, compares it against the broadcast key and
// takes its left or right neighbor's key when the row shifts
// ----------------------------------------------------------------------------
`default_nettype none

module skte_cell (
  input  logic                             clk_i,
  input  skte_pkg::bcast_t                 bc_i,
  input  logic [skte_pkg::IDX_W-1:0]       idx_i,
  input  logic                             left_lt_i,
  input  logic signed [skte_pkg::KEY_W-1:0] left_key_i,
  input  logic signed [skte_pkg::KEY_W-1:0] right_key_i,
  output logic signed [skte_pkg::KEY_W-1:0] key_o,
  output logic                             lt_o,
  output logic                             bnd_o
);
  import skte_pkg::*;

  logic signed [KEY_W-1:0] key_q;
  logic signed [KEY_W-1:0] key_d;

  // occupied and strictly below the broadcast key
  assign lt_o  = (CNT_W'(idx_i) < bc_i.count) && (key_q < bc_i.key);
  // first slot not below the key: the lower bound
  assign bnd_o = !lt_o && left_lt_i;
  assign key_o = key_q;

  // shift up on insert, shift down on delete
  always_comb begin
    key_d = key_q;
    if (bc_i.ins && !lt_o) begin
      key_d = left_lt_i ? bc_i.key : left_key_i;
    end else if (bc_i.del && (idx_i >= bc_i.pos)) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

`default_nettype wire

// ----- sv/skte_row.sv -----
// ----------------------------------------------------------------------------
// skte_row
// chain of table cells with the lower-bound encoder and the key read port
// ----------------------------------------------------------------------------
`default_nettype none

module skte_row (
  input  logic                              clk_i,
  input  skte_pkg::bcast_t                  bc_i,
  input  logic [skte_pkg::IDX_W-1:0]        rd_idx_i,
  output logic signed [skte_pkg::KEY_W-1:0] rd_key_o,
  output logic [skte_pkg::CNT_W-1:0]        lb_pos_o
);
  import skte_pkg::*;

  logic signed [KEY_W-1:0] keys [CAPACITY];
  logic [CAPACITY-1:0]     lt;
  logic [CAPACITY-1:0]     bnd;

  // cell chain, each cell sees its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    left_lt;
    logic signed [KEY_W-1:0] left_key;
    logic signed [KEY_W-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_key = bc_i.key;
    end else begin : g_mid
      assign left_lt  = lt[i-1];
      assign left_key = keys[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key = keys[i];
    end else begin : g_inner
      assign right_key = keys[i+1];
    end

    skte_cell u_cell (
      .clk_i       (clk_i),
      .bc_i        (bc_i),
      .idx_i       (IDX_W'(i)),
      .left_lt_i   (left_lt),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .key_o       (keys[i]),
      .lt_o        (lt[i]),
      .bnd_o       (bnd[i])
    );
  end

  // one-hot boundary to position, capacity when every slot is below the key
  always_comb begin
    logic [CNT_W-1:0] acc;
    logic             any;
    acc = '0;
    any = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bnd[i]) begin
        acc = acc | CNT_W'(i);
        any = 1'b1;
      end
    end
    lb_pos_o = any ? acc : CNT_W'(CAPACITY);
  end

  // key read for result items
  assign rd_key_o = keys[rd_idx_i];

endmodule

`default_nettype wire

// ----- tb/sorted_key_table_engine_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table_engine_tb
// Self-checking bench for the sorted key table engine. A short scripted
// sequence walks the empty table, the key extremes, duplicate keys, every
// command and the miss and bad statuses, then random traffic grows the table
// to full, hammers it there and drains it again. A shadow copy of the sorted
// table predicts each result item the script does not give, and every result
// item is compared field by field with what the block returns. Both sides
// idle in random bursts, the output is held off once long enough to back up
// the input, and the sender stops once until every result is home.
// ----------------------------------------------------------------------------

module sorted_key_table_engine_tb;
  import skte_pkg::*;

  // spare command encoding outside the enum
  localparam cmd_e CMD_SPARE   = cmd_e'(3'd7);
  localparam int   HOLD_CYCLES = 300;
  localparam int   STALL_LIMIT = 5000;
  localparam int   N_SCRIPT    = 25;

  typedef struct packed {
    in_item_t  cmd_item;
    logic      typed;
    out_item_t want;
  } script_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  // shadow of the sorted table
  logic signed [KEY_W-1:0] shadow_keys [CAPACITY];
  int                      shadow_count = 0;

  out_item_t   pending_results [$];
  out_item_t   got_res;
  out_item_t   want_res;
  script_row_t script [N_SCRIPT];

  int errs        = 0;
  int n_issued    = 0;
  int n_checked   = 0;
  int n_full      = 0;
  int peak_count  = 0;
  int idle_cycles = 0;
  bit hold_req    = 1'b0;
  bit quiet       = 1'b0;
  bit gap_on      = 1'b1;

  sorted_key_table_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // first slot whose key is not below k
  function automatic int lower_bound(logic signed [KEY_W-1:0] k);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = shadow_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (shadow_keys[mid] < k) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // apply one command to the shadow table and return its result item
  function automatic out_item_t predict_result(in_item_t it);
    out_item_t               r;
    logic signed [KEY_W-1:0] k;
    int                      n;
    int                      p;
    int                      lb;
    int                      i;
    k = it.key;
    n = shadow_count;
    p = int'(it.position);
    r = '0;
    r.status = ST_OK;
    case (it.cmd)
      CMD_INSERT: begin
        if (n >= CAPACITY) r.status = ST_FULL;
        else begin
          lb = lower_bound(k);
          for (i = n; i > lb; i--) shadow_keys[i] = shadow_keys[i-1];
          shadow_keys[lb] = k;
          shadow_count = n + 1;
          r.where = WHERE_W'(lb);
        end
      end
      CMD_DELETE: begin
        if (p >= n) r.status = ST_BAD;
        else begin
          for (i = p; i + 1 < n; i++) shadow_keys[i] = shadow_keys[i+1];
          shadow_count = n - 1;
        end
      end
      CMD_SEARCH: begin
        lb = lower_bound(k);
        if (lb < n && shadow_keys[lb] == k) begin
          r.value = k;
          r.where = WHERE_W'(lb);
        end else r.status = ST_MISS;
      end
      CMD_PRED: begin
        if (p >= n) r.status = ST_BAD;
        else if (p == 0) r.status = ST_MISS;
        else begin
          r.value = shadow_keys[p-1];
          r.where = WHERE_W'(p - 1);
        end
      end
      CMD_SUCC: begin
        if (p >= n) r.status = ST_BAD;
        else if (p + 1 >= n) r.status = ST_MISS;
        else begin
          r.value = shadow_keys[p+1];
          r.where = WHERE_W'(p + 1);
        end
      end
      CMD_MIN: begin
        if (n == 0) r.status = ST_BAD;
        else r.value = shadow_keys[0];
      end
      CMD_MAX: begin
        if (n == 0) r.status = ST_BAD;
        else begin
          r.value = shadow_keys[n-1];
          r.where = WHERE_W'(n - 1);
        end
      end
      default: r.status = ST_BAD;
    endcase
    r.count = COUNT_W'(shadow_count);
    return r;
  endfunction

  function automatic script_row_t mk_row(cmd_e c, logic [KEY_W-1:0] k, int p,
                                         bit typed, status_e s,
                                         logic [KEY_W-1:0] v, int w, int n);
    script_row_t row;
    row.cmd_item.cmd      = c;
    row.cmd_item.key      = k;
    row.cmd_item.position = POS_W'(p);
    row.typed             = typed;
    row.want.status       = s;
    row.want.value        = v;
    row.want.where        = WHERE_W'(w);
    row.want.count        = COUNT_W'(n);
    return row;
  endfunction

  // keys: full range, a narrow band for duplicates, extremes, stored keys
  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 7))
      0, 1, 2: return $urandom;
      3, 4:    return KEY_W'(int'($urandom_range(0, 16)) - 8);
      5: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: begin
        if (shadow_count == 0) return $urandom;
        return shadow_keys[$urandom_range(0, shadow_count - 1)];
      end
    endcase
  endfunction

  // positions: mostly in range, with the edges and just past the end
  function automatic logic [POS_W-1:0] rand_pos();
    if (shadow_count == 0 || $urandom_range(0, 4) == 0)
      return POS_W'($urandom_range(0, CAPACITY - 1));
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return POS_W'(shadow_count - 1);
      2:       return POS_W'(shadow_count);
      default: return POS_W'($urandom_range(0, shadow_count - 1));
    endcase
  endfunction

  function automatic in_item_t rand_item(int ins_w, int del_w);
    in_item_t it;
    int       r;
    r = $urandom_range(0, 99);
    if (r < ins_w) it.cmd = CMD_INSERT;
    else if (r < ins_w + del_w) it.cmd = CMD_DELETE;
    else begin
      case ($urandom_range(0, 10))
        0, 1, 2, 9: it.cmd = CMD_SEARCH;
        3, 4:       it.cmd = CMD_PRED;
        5, 6:       it.cmd = CMD_SUCC;
        7:          it.cmd = CMD_MIN;
        8:          it.cmd = CMD_MAX;
        default:    it.cmd = CMD_SPARE;
      endcase
    end
    it.key      = rand_key();
    it.position = rand_pos();
    return it;
  endfunction

  function automatic void cmp_field(string name, logic [KEY_W-1:0] want,
                                    logic [KEY_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      errs++;
    end
  endfunction

  // present one item and hold it until taken, then record what it should give
  task automatic offer(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t pred;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    pred = predict_result(it);
    pending_results.push_back(typed ? typed_res : pred);
    n_issued++;
    if (pred.status == ST_FULL) n_full++;
    if (shadow_count > peak_count) peak_count = shadow_count;
  endtask

  // random item with an occasional sender gap
  task automatic send_random(input int ins_w, input int del_w);
    if (!quiet) begin
      if (n_issued % 40 == 0) gap_on = ($urandom_range(0, 3) != 0);
      if (gap_on && $urandom_range(0, 5) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
    offer(rand_item(ins_w, del_w), 1'b0, '0);
  endtask

  // main sequence
  initial begin : stimulus
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;

    // empty table, extremes, duplicates, every command and every status but full
    script[ 0] = mk_row(CMD_MIN,    0,            0,    1, ST_BAD,  0, 0, 0);
    script[ 1] = mk_row(CMD_MAX,    0,            0,    1, ST_BAD,  0, 0, 0);
    script[ 2] = mk_row(CMD_SEARCH, 0,            0,    1, ST_MISS, 0, 0, 0);
    script[ 3] = mk_row(CMD_DELETE, 0,            0,    1, ST_BAD,  0, 0, 0);
    script[ 4] = mk_row(CMD_PRED,   0,            0,    1, ST_BAD,  0, 0, 0);
    script[ 5] = mk_row(CMD_SUCC,   0,            1023, 1, ST_BAD,  0, 0, 0);
    script[ 6] = mk_row(CMD_SPARE,  32'hffffffff, 1023, 1, ST_BAD,  0, 0, 0);
    script[ 7] = mk_row(CMD_INSERT, 32'h7fffffff, 0,    1, ST_OK,   0, 0, 1);
    script[ 8] = mk_row(CMD_INSERT, 32'h80000000, 0,    1, ST_OK,   0, 0, 2);
    script[ 9] = mk_row(CMD_INSERT, 0,            0,    1, ST_OK,   0, 1, 3);
    script[10] = mk_row(CMD_INSERT, 0,            0,    1, ST_OK,   0, 1, 4);
    script[11] = mk_row(CMD_INSERT, 32'hffffffff, 0,    1, ST_OK,   0, 1, 5);
    script[12] = mk_row(CMD_SEARCH, 0,            0,    1, ST_OK,   0, 2, 5);
    script[13] = mk_row(CMD_SEARCH, 5,            0,    1, ST_MISS, 0, 0, 5);
    script[14] = mk_row(CMD_MIN,    0,            0,    1, ST_OK,   32'h80000000, 0, 5);
    script[15] = mk_row(CMD_MAX,    0,            0,    1, ST_OK,   32'h7fffffff, 4, 5);
    script[16] = mk_row(CMD_PRED,   0,            0,    1, ST_MISS, 0, 0, 5);
    script[17] = mk_row(CMD_SUCC,   0,            4,    1, ST_MISS, 0, 0, 5);
    script[18] = mk_row(CMD_PRED,   0,            2,    0, ST_OK,   0, 0, 0);
    script[19] = mk_row(CMD_SUCC,   0,            1,    0, ST_OK,   0, 0, 0);
    script[20] = mk_row(CMD_PRED,   0,            5,    1, ST_BAD,  0, 0, 5);
    script[21] = mk_row(CMD_DELETE, 0,            1023, 1, ST_BAD,  0, 0, 5);
    script[22] = mk_row(CMD_DELETE, 0,            4,    1, ST_OK,   0, 0, 4);
    script[23] = mk_row(CMD_DELETE, 0,            0,    1, ST_OK,   0, 0, 3);
    script[24] = mk_row(CMD_SEARCH, 32'h55555555, 682,  0, ST_OK,   0, 0, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) offer(script[i].cmd_item, script[i].typed, script[i].want);

    // balanced mix
    repeat (700) send_random(35, 20);

    // long output hold while items keep coming
    hold_req = 1'b1;
    repeat (40) offer(rand_item(40, 20), 1'b0, '0);

    // sender pause until every result is home
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);

    // grow to full, then keep pushing against the full table
    while (shadow_count < CAPACITY) send_random(92, 0);
    repeat (20) send_random(50, 0);

    // drain with both sides running free
    quiet = 1'b1;
    repeat (300) offer(rand_item(10, 60), 1'b0, '0);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("checked %0d results from %0d commands, table peaked at %0d of %0d keys",
             n_checked, n_issued, peak_count, CAPACITY);
    $display("%0d inserts refused on a full table, one output hold of %0d cycles",
             n_full, HOLD_CYCLES);
    if (errs == 0) begin
      $display("sorted_key_table_engine_tb: clean");
    end else begin
      $display("sorted_key_table_engine_tb: errors");
    end
    $finish;
  end

  // output side: random stall bursts, free stretches and one long hold
  initial begin : receiver
    int free_left;
    free_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (quiet) begin
        free_left = 0;
      end else if (free_left > 0) begin
        free_left--;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:9]: begin
            out_stall_i <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clk_i);
            out_stall_i <= 1'b0;
          end
          [10:12]: free_left = $urandom_range(20, 80);
          default: ;
        endcase
      end
    end
  end

  // compare each result item with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result item arrived with no command outstanding");
        errs++;
      end else begin
        want_res = pending_results.pop_front();
        got_res  = out_item_o;
        cmp_field("status", KEY_W'(want_res.status), KEY_W'(got_res.status));
        cmp_field("value",  want_res.value,          got_res.value);
        cmp_field("where",  KEY_W'(want_res.where),  KEY_W'(got_res.where));
        cmp_field("count",  KEY_W'(want_res.count),  KEY_W'(got_res.count));
        n_checked++;
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("sorted_key_table_engine_tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
